### rtl/kalman_cv_covariance_update_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the covariance update block
// Immediate-consequence and next-cycle implications, clocked on clk.
// ----------------------------------------------------------------------------
`ifndef KALMAN_CV_COVARIANCE_UPDATE_ASSERT_SVH
`define KALMAN_CV_COVARIANCE_UPDATE_ASSERT_SVH

// same-cycle implication
`define KCV_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define KCV_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/kcv_pkg.sv
// ----------------------------------------------------------------------------
// kcv_pkg
// Types, codes, saturation helpers and the micro-op table of the update block.
// ----------------------------------------------------------------------------
package kcv_pkg;

	localparam int unsigned NumEntries = 10;
	localparam int unsigned NumGains   = 7;
	localparam int unsigned NumNoise   = 4;
	localparam int unsigned PcW        = 6;

	localparam logic signed [31:0] QOne = 32'sd65536;

	localparam logic [30:0] RstNoise0 = 31'd65536;
	localparam logic [30:0] RstNoise1 = 31'd65536;
	localparam logic [30:0] RstNoise2 = 31'd655360;
	localparam logic [30:0] RstNoise3 = 31'd655360;

	typedef enum logic [1:0] {
		OPC_WRITE  = 2'd0,
		OPC_READ   = 2'd1,
		OPC_PRED   = 2'd2,
		OPC_UPDATE = 2'd3
	} opc_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_WRITE, ST_READ, ST_ISSUE, ST_MULWB, ST_DIVW, ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		PH_PRED, PH_GA, PH_GB, PH_AX
	} phase_t;

	typedef enum logic [2:0] {
		OP_LDA, OP_LDN, OP_ADDA, OP_SUBA, OP_STA, OP_MUL, OP_DIV
	} aluop_t;

	typedef enum logic [3:0] {
		SRC_ONE, SRC_PI, SRC_PJ, SRC_PC, SRC_GI, SRC_GJ, SRC_R,
		SRC_T0, SRC_T1, SRC_T2, SRC_T3
	} src_t;

	typedef enum logic [3:0] {
		DST_NONE, DST_PI, DST_PJ, DST_PC, DST_GI, DST_GJ,
		DST_T0, DST_T1, DST_T2, DST_T3
	} dst_t;

	typedef struct packed {
		aluop_t op;
		src_t   a;
		src_t   b;
		dst_t   dst;
		logic   seg_end;
	} uop_t;

	typedef struct packed {
		logic       load;
		logic       wr_entry;
		logic       rd_entry;
		logic       exec;
		logic       wb;
		logic       div_wait;
		logic       emit;
		logic       last;
		logic [2:0] gidx;
		logic [1:0] ax;
		uop_t       uop;
	} dp_cmd_t;

	typedef struct packed {
		logic div_done;
	} dp_stat_t;

	// segment starts and ends in the micro-op table
	localparam logic [PcW-1:0] PcPred    = 6'd0;
	localparam logic [PcW-1:0] PcGa      = 6'd8;
	localparam logic [PcW-1:0] PcGb      = 6'd11;
	localparam logic [PcW-1:0] PcAx      = 6'd14;
	localparam logic [PcW-1:0] PcMEnd    = 6'd16;
	localparam logic [PcW-1:0] PcD       = 6'd17;
	localparam logic [PcW-1:0] PcV       = 6'd37;

	function automatic uop_t mk(aluop_t op, src_t a, src_t b, dst_t d, logic e);
		uop_t u;
		u.op      = op;
		u.a       = a;
		u.b       = b;
		u.dst     = d;
		u.seg_end = e;
		return u;
	endfunction

	// acc is the wide accumulator; T0=m, T1=d, T2/T3 scratch
	function automatic uop_t uop_rom(logic [PcW-1:0] pc);
		uop_t u;
		case (pc)
			// predict: P[i]=P[i]+P[j]+2P[c], P[c]=P[c]+P[j]
			6'd0:  u = mk(OP_LDA,  SRC_PI,  SRC_ONE, DST_NONE, 1'b0);
			6'd1:  u = mk(OP_ADDA, SRC_PJ,  SRC_ONE, DST_NONE, 1'b0);
			6'd2:  u = mk(OP_ADDA, SRC_PC,  SRC_ONE, DST_NONE, 1'b0);
			6'd3:  u = mk(OP_ADDA, SRC_PC,  SRC_ONE, DST_NONE, 1'b0);
			6'd4:  u = mk(OP_STA,  SRC_ONE, SRC_ONE, DST_PI,   1'b0);
			6'd5:  u = mk(OP_LDA,  SRC_PC,  SRC_ONE, DST_NONE, 1'b0);
			6'd6:  u = mk(OP_ADDA, SRC_PJ,  SRC_ONE, DST_NONE, 1'b0);
			6'd7:  u = mk(OP_STA,  SRC_ONE, SRC_ONE, DST_PC,   1'b1);
			// position gains
			6'd8:  u = mk(OP_LDA,  SRC_PI,  SRC_ONE, DST_NONE, 1'b0);
			6'd9:  u = mk(OP_ADDA, SRC_R,   SRC_ONE, DST_NONE, 1'b0);
			6'd10: u = mk(OP_DIV,  SRC_PI,  SRC_ONE, DST_GI,   1'b1);
			// velocity gains
			6'd11: u = mk(OP_LDA,  SRC_PI,  SRC_ONE, DST_NONE, 1'b0);
			6'd12: u = mk(OP_ADDA, SRC_R,   SRC_ONE, DST_NONE, 1'b0);
			6'd13: u = mk(OP_DIV,  SRC_PC,  SRC_ONE, DST_GJ,   1'b1);
			// m = 1 - k
			6'd14: u = mk(OP_LDA,  SRC_ONE, SRC_ONE, DST_NONE, 1'b0);
			6'd15: u = mk(OP_SUBA, SRC_GI,  SRC_ONE, DST_NONE, 1'b0);
			6'd16: u = mk(OP_STA,  SRC_ONE, SRC_ONE, DST_T0,   1'b1);
			// d = P[c] - kv*P[i]
			6'd17: u = mk(OP_MUL,  SRC_GJ,  SRC_PI,  DST_T1,   1'b0);
			6'd18: u = mk(OP_LDA,  SRC_PC,  SRC_ONE, DST_NONE, 1'b0);
			6'd19: u = mk(OP_SUBA, SRC_T1,  SRC_ONE, DST_NONE, 1'b0);
			6'd20: u = mk(OP_STA,  SRC_ONE, SRC_ONE, DST_T1,   1'b0);
			// P[j] = kv*(-P[c]-d) + P[j] + kv*kv*R
			6'd21: u = mk(OP_LDN,  SRC_PC,  SRC_ONE, DST_NONE, 1'b0);
			6'd22: u = mk(OP_SUBA, SRC_T1,  SRC_ONE, DST_NONE, 1'b0);
			6'd23: u = mk(OP_STA,  SRC_ONE, SRC_ONE, DST_T2,   1'b0);
			6'd24: u = mk(OP_MUL,  SRC_GJ,  SRC_T2,  DST_T2,   1'b0);
			6'd25: u = mk(OP_MUL,  SRC_GJ,  SRC_GJ,  DST_T3,   1'b0);
			6'd26: u = mk(OP_MUL,  SRC_T3,  SRC_R,   DST_T3,   1'b0);
			6'd27: u = mk(OP_LDA,  SRC_T2,  SRC_ONE, DST_NONE, 1'b0);
			6'd28: u = mk(OP_ADDA, SRC_PJ,  SRC_ONE, DST_NONE, 1'b0);
			6'd29: u = mk(OP_ADDA, SRC_T3,  SRC_ONE, DST_NONE, 1'b0);
			6'd30: u = mk(OP_STA,  SRC_ONE, SRC_ONE, DST_PJ,   1'b0);
			// P[c] = d*m + k*kv*R
			6'd31: u = mk(OP_MUL,  SRC_T1,  SRC_T0,  DST_T2,   1'b0);
			6'd32: u = mk(OP_MUL,  SRC_GI,  SRC_GJ,  DST_T3,   1'b0);
			6'd33: u = mk(OP_MUL,  SRC_T3,  SRC_R,   DST_T3,   1'b0);
			6'd34: u = mk(OP_LDA,  SRC_T2,  SRC_ONE, DST_NONE, 1'b0);
			6'd35: u = mk(OP_ADDA, SRC_T3,  SRC_ONE, DST_NONE, 1'b0);
			6'd36: u = mk(OP_STA,  SRC_ONE, SRC_ONE, DST_PC,   1'b0);
			// P[i] = P[i]*m*m + k*k*R
			6'd37: u = mk(OP_MUL,  SRC_PI,  SRC_T0,  DST_T2,   1'b0);
			6'd38: u = mk(OP_MUL,  SRC_T2,  SRC_T0,  DST_T2,   1'b0);
			6'd39: u = mk(OP_MUL,  SRC_GI,  SRC_GI,  DST_T3,   1'b0);
			6'd40: u = mk(OP_MUL,  SRC_T3,  SRC_R,   DST_T3,   1'b0);
			6'd41: u = mk(OP_LDA,  SRC_T2,  SRC_ONE, DST_NONE, 1'b0);
			6'd42: u = mk(OP_ADDA, SRC_T3,  SRC_ONE, DST_NONE, 1'b0);
			6'd43: u = mk(OP_STA,  SRC_ONE, SRC_ONE, DST_PI,   1'b1);
			default: u = mk(OP_LDA, SRC_ONE, SRC_ONE, DST_NONE, 1'b1);
		endcase
		return u;
	endfunction

	function automatic logic signed [31:0] sat36(logic signed [35:0] x);
		logic signed [31:0] r;
		if (x > 36'sd2147483647)
			r = 32'sh7fffffff;
		else if (x < -36'sd2147483648)
			r = 32'sh80000000;
		else
			r = x[31:0];
		return r;
	endfunction

	function automatic logic signed [31:0] sat48(logic signed [47:0] x);
		logic signed [31:0] r;
		if (x > 48'sd2147483647)
			r = 32'sh7fffffff;
		else if (x < -48'sd2147483648)
			r = 32'sh80000000;
		else
			r = x[31:0];
		return r;
	endfunction

endpackage

### rtl/kcv_div.sv
// ----------------------------------------------------------------------------
// kcv_div
// Bit-serial restoring divider: sat32(num*65536/den), truncated toward zero.
// ----------------------------------------------------------------------------
module kcv_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] num,
	input  logic signed [35:0] den,
	output logic               done,
	output logic               err,
	output logic signed [31:0] quot
);
	import kcv_pkg::*;

	localparam int unsigned QW = 48;

	logic              run_q;
	logic              done_q;
	logic              zero_q;
	logic              neg_q;
	logic [5:0]        cnt_q;
	logic [36:0]       rem_q;
	logic [QW-1:0]     dvd_q;
	logic [35:0]       dmag_q;

	logic [31:0]       nmag;
	logic [35:0]       dmag;
	logic [36:0]       rem_sh;
	logic              ge;

	assign nmag   = num[31] ? (~num + 32'd1) : num;
	assign dmag   = den[35] ? (~den + 36'd1) : den;
	assign rem_sh = {rem_q[35:0], dvd_q[QW-1]};
	assign ge     = rem_sh >= {1'b0, dmag_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= (den != 36'sd0);
				done_q <= (den == 36'sd0);
			end else if (run_q && cnt_q == 6'(QW - 1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			zero_q <= (den == 36'sd0);
			neg_q  <= num[31] ^ den[35];
			cnt_q  <= 6'd0;
			rem_q  <= '0;
			dvd_q  <= {nmag, 16'd0};
			dmag_q <= dmag;
		end else if (run_q) begin
			cnt_q <= cnt_q + 6'd1;
			rem_q <= ge ? (rem_sh - {1'b0, dmag_q}) : rem_sh;
			dvd_q <= {dvd_q[QW-2:0], ge};
		end
	end

	always_comb begin
		if (zero_q)
			quot = 32'sd0;
		else if (neg_q)
			quot = (dvd_q > 48'd2147483648) ? 32'sh80000000 : (~dvd_q[31:0] + 32'd1);
		else
			quot = (dvd_q > 48'd2147483647) ? 32'sh7fffffff : dvd_q[31:0];
	end

	assign done = done_q;
	assign err  = zero_q;

endmodule

### rtl/kcv_dp.sv
// ----------------------------------------------------------------------------
// kcv_dp
// Datapath: covariance, gains, noise registers, accumulator, shared
// multiplier and divider, result register.
// ----------------------------------------------------------------------------
module kcv_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  kcv_pkg::dp_cmd_t    cmd,
	output kcv_pkg::dp_stat_t   stat,
	input  logic [3:0]          entry_index,
	input  logic signed [31:0]  write_value,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [30:0]         cfg_data,
	output logic                result_valid,
	output logic                result_kind,
	output logic [3:0]          result_index,
	output logic signed [31:0]  result_value,
	output logic                last_of_run,
	output logic                divide_error
);
	import kcv_pkg::*;

	logic signed [31:0] p_q [NumEntries];
	logic signed [31:0] g_q [NumGains];
	logic               ge_q [NumGains];
	logic [30:0]        r_q [NumNoise];
	logic signed [31:0] t_q [4];
	logic signed [35:0] acc_q;
	logic signed [63:0] prod_s1;
	logic [3:0]         idx_q;
	logic signed [31:0] wval_q;

	logic               res_valid_q;
	logic               res_kind_q;
	logic [3:0]         res_index_q;
	logic signed [31:0] res_value_q;
	logic               res_last_q;
	logic               res_err_q;

	logic [3:0]         pi_idx, pj_idx, pc_idx;
	logic [2:0]         gi_idx, gj_idx;
	logic signed [31:0] a_val, b_val;
	logic signed [35:0] a_ext;
	logic               wb_en;
	logic signed [31:0] wb_data;
	logic signed [31:0] mul_sat;
	logic               div_start;
	logic               div_done;
	logic               div_err;
	logic signed [31:0] div_quot;

	assign pi_idx = {2'b00, cmd.ax};
	assign pj_idx = pi_idx + 4'd4;
	assign pc_idx = pi_idx + 4'd7;
	assign gi_idx = {1'b0, cmd.ax};
	assign gj_idx = gi_idx + 3'd4;

	function automatic logic signed [31:0] src_val(
		src_t s, logic signed [31:0] pi, logic signed [31:0] pj, logic signed [31:0] pc,
		logic signed [31:0] gi, logic signed [31:0] gj, logic [30:0] r,
		logic signed [31:0] t0, logic signed [31:0] t1, logic signed [31:0] t2,
		logic signed [31:0] t3);
		logic signed [31:0] v;
		case (s)
			SRC_ONE: v = QOne;
			SRC_PI:  v = pi;
			SRC_PJ:  v = pj;
			SRC_PC:  v = pc;
			SRC_GI:  v = gi;
			SRC_GJ:  v = gj;
			SRC_R:   v = {1'b0, r};
			SRC_T0:  v = t0;
			SRC_T1:  v = t1;
			SRC_T2:  v = t2;
			SRC_T3:  v = t3;
			default: v = 32'sd0;
		endcase
		return v;
	endfunction

	logic signed [31:0] pi_v, pj_v, pc_v, gi_v, gj_v;

	always_comb begin
		pi_v = (pi_idx < 4'(NumEntries)) ? p_q[pi_idx] : 32'sd0;
		pj_v = (pj_idx < 4'(NumEntries)) ? p_q[pj_idx] : 32'sd0;
		pc_v = (pc_idx < 4'(NumEntries)) ? p_q[pc_idx] : 32'sd0;
		gi_v = (gi_idx < 3'(NumGains)) ? g_q[gi_idx] : 32'sd0;
		gj_v = (gj_idx < 3'(NumGains)) ? g_q[gj_idx] : 32'sd0;
		a_val = src_val(cmd.uop.a, pi_v, pj_v, pc_v, gi_v, gj_v, r_q[cmd.ax],
			t_q[0], t_q[1], t_q[2], t_q[3]);
		b_val = src_val(cmd.uop.b, pi_v, pj_v, pc_v, gi_v, gj_v, r_q[cmd.ax],
			t_q[0], t_q[1], t_q[2], t_q[3]);
	end

	assign a_ext     = {{4{a_val[31]}}, a_val};
	assign mul_sat   = sat48(prod_s1[63:16]);
	assign wb_en     = (cmd.exec && cmd.uop.op == OP_STA) || cmd.wb;
	assign wb_data   = cmd.wb ? mul_sat : sat36(acc_q);
	assign div_start = cmd.exec && cmd.uop.op == OP_DIV;

	kcv_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (a_val),
		.den    (acc_q),
		.done   (div_done),
		.err    (div_err),
		.quot   (div_quot)
	);

	assign stat.div_done = div_done;

	// accumulator and multiplier stage
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			case (cmd.uop.op)
				OP_LDA:  acc_q <= a_ext;
				OP_LDN:  acc_q <= -a_ext;
				OP_ADDA: acc_q <= acc_q + a_ext;
				OP_SUBA: acc_q <= acc_q - a_ext;
				OP_MUL:  prod_s1 <= a_val * b_val;
				default: ;
			endcase
		end
		if (cmd.load) begin
			idx_q  <= entry_index;
			wval_q <= write_value;
		end
	end

	// covariance store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int n = 0; n < NumEntries; n++)
				p_q[n] <= 32'sd0;
		end else if (cmd.wr_entry) begin
			if (idx_q < 4'(NumEntries))
				p_q[idx_q] <= wval_q;
		end else if (wb_en) begin
			case (cmd.uop.dst)
				DST_PI: if (pi_idx < 4'(NumEntries)) p_q[pi_idx] <= wb_data;
				DST_PJ: if (pj_idx < 4'(NumEntries)) p_q[pj_idx] <= wb_data;
				DST_PC: if (pc_idx < 4'(NumEntries)) p_q[pc_idx] <= wb_data;
				default: ;
			endcase
		end
	end

	// scratch registers
	always_ff @(posedge clk) begin
		if (wb_en) begin
			case (cmd.uop.dst)
				DST_T0:  t_q[0] <= wb_data;
				DST_T1:  t_q[1] <= wb_data;
				DST_T2:  t_q[2] <= wb_data;
				DST_T3:  t_q[3] <= wb_data;
				default: ;
			endcase
		end
	end

	// gains
	always_ff @(posedge clk) begin
		if (cmd.div_wait && div_done) begin
			if (cmd.uop.dst == DST_GI) begin
				g_q[gi_idx]  <= div_quot;
				ge_q[gi_idx] <= div_err;
			end else if (gj_idx < 3'(NumGains)) begin
				g_q[gj_idx]  <= div_quot;
				ge_q[gj_idx] <= div_err;
			end
		end
	end

	// noise registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q[0] <= RstNoise0;
			r_q[1] <= RstNoise1;
			r_q[2] <= RstNoise2;
			r_q[3] <= RstNoise3;
		end else if (cfg_we) begin
			r_q[cfg_index] <= cfg_data;
		end
	end

	// result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else
			res_valid_q <= cmd.rd_entry || cmd.emit;
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_entry) begin
			res_kind_q  <= 1'b0;
			res_index_q <= idx_q;
			res_value_q <= (idx_q < 4'(NumEntries)) ? p_q[idx_q] : 32'sd0;
			res_last_q  <= 1'b1;
			res_err_q   <= 1'b0;
		end else if (cmd.emit) begin
			res_kind_q  <= 1'b1;
			res_index_q <= {1'b0, cmd.gidx};
			res_value_q <= g_q[cmd.gidx];
			res_last_q  <= cmd.last;
			res_err_q   <= ge_q[cmd.gidx];
		end
	end

	assign result_valid = res_valid_q;
	assign result_kind  = res_kind_q;
	assign result_index = res_index_q;
	assign result_value = res_value_q;
	assign last_of_run  = res_last_q;
	assign divide_error = res_err_q;

endmodule

### rtl/kcv_ctrl.sv
// ----------------------------------------------------------------------------
// kcv_ctrl
// Controller: decodes commands and steps the micro-op table.
// ----------------------------------------------------------------------------
module kcv_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [1:0]        opcode,
	input  logic [3:0]        entry_index,
	output logic              busy,
	output kcv_pkg::dp_cmd_t  cmd,
	input  kcv_pkg::dp_stat_t stat
);
	import kcv_pkg::*;

	state_t         state_q, state_d;
	phase_t         phase_q, adv_phase;
	logic [PcW-1:0] pc_q, adv_pc;
	logic [1:0]     ax_q, adv_ax;
	logic [2:0]     n_q;
	logic           adv_finish;
	logic           step;
	logic           accept;
	uop_t           uop;
	opc_t           opc;

	assign uop    = uop_rom(pc_q);
	assign accept = start && state_q == ST_IDLE;
	assign opc    = opc_t'(opcode);
	assign step   = (state_q == ST_ISSUE && uop.op != OP_MUL && uop.op != OP_DIV) ||
	                state_q == ST_MULWB ||
	                (state_q == ST_DIVW && stat.div_done);

	// sequencing between table segments
	always_comb begin
		adv_pc     = pc_q + 6'd1;
		adv_ax     = ax_q;
		adv_phase  = phase_q;
		adv_finish = 1'b0;
		if (uop.seg_end) begin
			case (phase_q)
				PH_PRED: adv_finish = 1'b1;
				PH_GA: begin
					if (ax_q == 2'd3) begin
						adv_ax    = 2'd0;
						adv_pc    = PcGb;
						adv_phase = PH_GB;
					end else begin
						adv_ax = ax_q + 2'd1;
						adv_pc = PcGa;
					end
				end
				PH_GB: begin
					if (ax_q == 2'd2) begin
						adv_ax    = 2'd0;
						adv_pc    = PcAx;
						adv_phase = PH_AX;
					end else begin
						adv_ax = ax_q + 2'd1;
						adv_pc = PcGb;
					end
				end
				PH_AX: begin
					if (pc_q == PcMEnd) begin
						// scale/aspect variance has no velocity terms
						adv_pc = (ax_q == 2'd3) ? PcV : PcD;
					end else if (ax_q == 2'd3) begin
						adv_finish = 1'b1;
					end else begin
						adv_ax = ax_q + 2'd1;
						adv_pc = PcAx;
					end
				end
				default: adv_finish = 1'b1;
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (opc)
						OPC_WRITE:  state_d = ST_WRITE;
						OPC_READ:   state_d = ST_READ;
						OPC_PRED:   state_d = (entry_index < 4'd3) ? ST_ISSUE : ST_IDLE;
						OPC_UPDATE: state_d = ST_ISSUE;
						default:    state_d = ST_IDLE;
					endcase
				end
			end
			ST_WRITE, ST_READ: state_d = ST_IDLE;
			ST_ISSUE: begin
				if (uop.op == OP_MUL)
					state_d = ST_MULWB;
				else if (uop.op == OP_DIV)
					state_d = ST_DIVW;
			end
			ST_MULWB: state_d = ST_ISSUE;
			ST_DIVW: begin
				if (stat.div_done)
					state_d = ST_ISSUE;
			end
			ST_EMIT: begin
				if (n_q == 3'(NumGains - 1))
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
		if (step && adv_finish)
			state_d = (phase_q == PH_PRED) ? ST_IDLE : ST_EMIT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_PRED;
			pc_q    <= PcPred;
			ax_q    <= 2'd0;
			n_q     <= 3'd0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				n_q <= 3'd0;
				if (opc == OPC_PRED) begin
					phase_q <= PH_PRED;
					pc_q    <= PcPred;
					ax_q    <= entry_index[1:0];
				end else begin
					phase_q <= PH_GA;
					pc_q    <= PcGa;
					ax_q    <= 2'd0;
				end
			end else if (step) begin
				pc_q    <= adv_pc;
				ax_q    <= adv_ax;
				phase_q <= adv_phase;
			end else if (state_q == ST_EMIT) begin
				n_q <= n_q + 3'd1;
			end
		end
	end

	// outputs
	always_comb begin
		cmd          = '0;
		cmd.load     = accept;
		cmd.uop      = uop;
		cmd.ax       = ax_q;
		cmd.gidx     = n_q;
		cmd.last     = (n_q == 3'(NumGains - 1));
		case (state_q)
			ST_WRITE: cmd.wr_entry = 1'b1;
			ST_READ:  cmd.rd_entry = 1'b1;
			ST_ISSUE: cmd.exec     = 1'b1;
			ST_MULWB: cmd.wb       = 1'b1;
			ST_DIVW:  cmd.div_wait = 1'b1;
			ST_EMIT:  cmd.emit     = 1'b1;
			default:  ;
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule

### rtl/kalman_cv_covariance_update.sv
// ----------------------------------------------------------------------------
// kalman_cv_covariance_update
// Sparse constant-velocity covariance store with predict and Joseph update.
// ----------------------------------------------------------------------------
// channel   direction  handshake              word
// command   in         start & !busy          opcode, entry_index, write_value
// result    out        result_valid strobe    result_kind/index/value, last, error
// config    in         cfg_valid & cfg_ready  cfg_index, cfg_data
//
// A read gives one registered result word; write and predict give none.
// Update: 7 gains, each of two accumulate steps, a divide issue and a wait on
// the one serial divider (a zero denominator skips the serial steps), then
// accumulate and shared 32x32 multiply steps, then 7 result words; the update
// time is set by the bit-serial divider.
// Reset clears the covariance to zero and loads the noise defaults.
// Results are one-cycle strobes; the receiver cannot stall.
// ----------------------------------------------------------------------------
module kalman_cv_covariance_update (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         opcode,
	input  logic [3:0]         entry_index,
	input  logic signed [31:0] write_value,
	output logic               result_valid,
	output logic               result_kind,
	output logic [3:0]         result_index,
	output logic signed [31:0] result_value,
	output logic               last_of_run,
	output logic               divide_error,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [30:0]        cfg_data
);
	import kcv_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	assign cfg_ready = 1'b1;

	kcv_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.opcode      (opcode),
		.entry_index (entry_index),
		.busy        (busy),
		.cmd         (cmd),
		.stat        (stat)
	);

	kcv_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.entry_index  (entry_index),
		.write_value  (write_value),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.result_kind  (result_kind),
		.result_index (result_index),
		.result_value (result_value),
		.last_of_run  (last_of_run),
		.divide_error (divide_error)
	);

endmodule

### rtl/kcv_chk.sv
// ----------------------------------------------------------------------------
// kcv_chk
// Port-level checks of the covariance update block.
// ----------------------------------------------------------------------------
`include "kalman_cv_covariance_update_assert.svh"

module kcv_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic [1:0]         opcode,
	input logic               result_valid,
	input logic               result_kind,
	input logic [3:0]         result_index,
	input logic               last_of_run,
	input logic               divide_error
);
	import kcv_pkg::*;

	`KCV_ASSERT_IMP(a_res_after_busy, result_valid, $past(busy), "result word without work in flight")
	`KCV_ASSERT_IMP(a_gain_index, result_valid && result_kind, result_index <= 4'd6, "gain index out of range")
	`KCV_ASSERT_IMP(a_gain_last, result_valid && result_kind, last_of_run == (result_index == 4'd6), "gain last flag wrong")
	`KCV_ASSERT_IMP(a_read_word, result_valid && !result_kind, last_of_run && !divide_error, "read word flags wrong")
	`KCV_ASSERT_NXT(a_write_silent, start && !busy && opcode == OPC_WRITE, !result_valid, "write produced a word")

endmodule

bind kalman_cv_covariance_update kcv_chk u_kcv_chk (.*);

### tb/kalman_cv_covariance_update_test.sv
// ----------------------------------------------------------------------------
// kalman_cv_covariance_update_test
// Drives entry writes, reads, axis predicts and measurement updates into the
// covariance block under several noise settings. Every result word is checked
// field by field against a fixed-point in-bench store predictor or a row literal.
// ----------------------------------------------------------------------------
module kalman_cv_covariance_update_test;
	import kcv_pkg::*;

	typedef struct {
		logic        kind;
		logic [3:0]  idx;
		logic [31:0] value;
		logic        last;
		logic        err;
	} result_word_t;

	typedef struct {
		opc_t        op;
		logic [3:0]  idx;
		logic [31:0] wval;
		bit          has_lit;
		logic [31:0] lit;
	} cmd_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [1:0]         opcode = OPC_WRITE;
	logic [3:0]         entry_index = '0;
	logic signed [31:0] write_value = '0;
	logic               result_valid;
	logic               result_kind;
	logic [3:0]         result_index;
	logic signed [31:0] result_value;
	logic               last_of_run;
	logic               divide_error;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [1:0]         cfg_index = '0;
	logic [30:0]        cfg_data = '0;

	longint       cov_est [NumEntries];
	longint       noise_est [NumNoise];
	result_word_t pending_results [$];
	int           n_errors;
	int           n_cmds;
	int           n_reads;
	int           n_gains;
	int           n_div_zero;
	bit           gaps_on;

	kalman_cv_covariance_update u_top (.*);

	always #5 clk = ~clk;

	function automatic longint clamp32(longint x);
		if (x > 64'sd2147483647)
			return 64'sd2147483647;
		if (x < -64'sd2147483648)
			return -64'sd2147483648;
		return x;
	endfunction

	// arithmetic shift of a signed product floors, as the block rounds
	function automatic longint qmul(longint a, longint b);
		return clamp32((a * b) >>> 16);
	endfunction

	function automatic longint variance_upd(longint p, longint k, longint r);
		longint m;
		m = clamp32(64'sd65536 - k);
		return clamp32(qmul(qmul(p, m), m) + qmul(qmul(k, k), r));
	endfunction

	// a measurement update: returns gains and their zero-denominator flags
	task automatic joseph_update(output longint g [NumGains], output bit e [NumGains]);
		longint den, pii, pc, pjj, k, kv, r, m, d;
		int     j, c;
		for (int n = 0; n < NumGains; n++) begin
			int p;
			p   = (n < 4) ? n : n - 4;
			den = cov_est[p] + noise_est[p];
			e[n] = (den == 0);
			g[n] = e[n] ? 0 : clamp32((cov_est[(n < 4) ? n : n + 3] * 65536) / den);
		end
		for (int i = 0; i < 3; i++) begin
			j   = i + 4;
			c   = i + 7;
			pii = cov_est[i];
			pc  = cov_est[c];
			pjj = cov_est[j];
			k   = g[i];
			kv  = g[j];
			r   = noise_est[i];
			m   = clamp32(64'sd65536 - k);
			d   = clamp32(pc - qmul(kv, pii));
			cov_est[i] = variance_upd(pii, k, r);
			cov_est[c] = clamp32(qmul(d, m) + qmul(qmul(k, kv), r));
			cov_est[j] = clamp32(qmul(kv, clamp32(-pc - d)) + pjj + qmul(qmul(kv, kv), r));
		end
		cov_est[3] = variance_upd(cov_est[3], g[3], noise_est[3]);
	endtask

	// advance the predictor by one accepted command word, queue its results
	task automatic predict_cmd(opc_t op, logic [3:0] idx, logic [31:0] wv,
			bit has_lit, logic [31:0] lit);
		result_word_t w;
		longint       g [NumGains];
		bit           e [NumGains];
		longint       pj, pc;
		case (op)
			OPC_WRITE: begin
				if (idx < NumEntries)
					cov_est[idx] = longint'($signed(wv));
			end
			OPC_READ: begin
				w.kind  = 1'b0;
				w.idx   = idx;
				w.value = (idx < NumEntries) ? cov_est[idx][31:0] : 32'd0;
				if (has_lit)
					w.value = lit;
				w.last  = 1'b1;
				w.err   = 1'b0;
				pending_results.push_back(w);
				n_reads++;
			end
			OPC_PRED: begin
				if (idx < 3) begin
					pj = cov_est[idx + 4];
					pc = cov_est[idx + 7];
					cov_est[idx]     = clamp32(cov_est[idx] + pj + 2 * pc);
					cov_est[idx + 7] = clamp32(pc + pj);
				end
			end
			default: begin
				joseph_update(g, e);
				for (int n = 0; n < NumGains; n++) begin
					w.kind  = 1'b1;
					w.idx   = 4'(n);
					w.value = g[n][31:0];
					w.last  = (n == NumGains - 1);
					w.err   = e[n];
					n_div_zero += e[n];
					pending_results.push_back(w);
				end
				n_gains += NumGains;
			end
		endcase
	endtask

	task automatic send_cmd(opc_t op, logic [3:0] idx, logic [31:0] wv,
			bit has_lit = 0, logic [31:0] lit = 0);
		while (gaps_on && $urandom_range(99) < 21) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start       <= 1'b1;
		opcode      <= op;
		entry_index <= idx;
		write_value <= wv;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predict_cmd(op, idx, wv, has_lit, lit);
		n_cmds++;
	endtask

	// writes and predicts leave no result, so allow their latency before config
	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0 || busy)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_noise(logic [30:0] r0, logic [30:0] r1, logic [30:0] r2,
			logic [30:0] r3);
		logic [30:0] vals [NumNoise];
		vals = '{r0, r1, r2, r3};
		wait_drained();
		for (int n = 0; n < NumNoise; n++) begin
			cfg_valid <= 1'b1;
			cfg_index <= 2'(n);
			cfg_data  <= vals[n];
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
			noise_est[n] = vals[n];
		end
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(9))
			0, 1, 2: return $urandom_range(32'h0004_0000);
			3:       return -$urandom_range(32'h0004_0000);
			4, 5:    return $urandom;
			6:       return 32'h7fff_ffff;
			7:       return 32'h8000_0000;
			8:       return 32'd0;
			default: return {16'($urandom_range(8) - 4), 16'h0000};
		endcase
	endfunction

	// well-formed track step: load entries, predict, update, read back
	task automatic track_burst();
		repeat ($urandom_range(4, 1))
			send_cmd(OPC_WRITE, 4'($urandom_range(9)), pick_value());
		repeat ($urandom_range(2))
			send_cmd(OPC_PRED, 4'($urandom_range(2)), $urandom);
		send_cmd(OPC_UPDATE, 4'($urandom), $urandom);
		repeat ($urandom_range(3, 1))
			send_cmd(OPC_READ, 4'($urandom_range(9)), $urandom);
	endtask

	task automatic noise_cmd();
		send_cmd(opc_t'($urandom_range(3)), 4'($urandom), $urandom);
	endtask

	// results cannot be stalled: check every strobe against the oldest word
	always @(posedge clk) begin
		result_word_t w;
		if (arst_n && result_valid) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result word kind=%0d idx=%0d value=%h",
					$time, result_kind, result_index, result_value);
				n_errors++;
			end else begin
				w = pending_results.pop_front();
				if (result_kind !== w.kind || result_index !== w.idx ||
						result_value !== w.value || last_of_run !== w.last ||
						divide_error !== w.err) begin
					$display("%0t: mismatch expected kind=%0d idx=%0d value=%h last=%0d err=%0d",
						$time, w.kind, w.idx, w.value, w.last, w.err);
					$display("%0t:          actual   kind=%0d idx=%0d value=%h last=%0d err=%0d",
						$time, result_kind, result_index, result_value, last_of_run,
						divide_error);
					n_errors++;
				end
			end
		end
	end

	initial begin
		cmd_row_t dir_rows [0:20];
		dir_rows = '{
			'{OPC_READ,   4'd0,  32'h0,         1, 32'h0},
			'{OPC_WRITE,  4'd0,  32'h7fff_ffff, 0, 32'h0},
			'{OPC_READ,   4'd0,  32'h0,         1, 32'h7fff_ffff},
			'{OPC_WRITE,  4'd4,  32'h8000_0000, 0, 32'h0},
			'{OPC_READ,   4'd4,  32'h0,         1, 32'h8000_0000},
			'{OPC_READ,   4'd15, 32'hffff_ffff, 1, 32'h0},
			'{OPC_WRITE,  4'd12, 32'h0000_007b, 0, 32'h0},
			'{OPC_READ,   4'd12, 32'h0,         1, 32'h0},
			'{OPC_WRITE,  4'd7,  32'h7fff_ffff, 0, 32'h0},
			'{OPC_PRED,   4'd0,  32'h0,         0, 32'h0},
			'{OPC_READ,   4'd0,  32'h0,         0, 32'h0},
			'{OPC_PRED,   4'd9,  32'h0,         0, 32'h0},
			'{OPC_WRITE,  4'd1,  32'h0001_0000, 0, 32'h0},
			'{OPC_WRITE,  4'd8,  32'h0000_8000, 0, 32'h0},
			'{OPC_WRITE,  4'd5,  32'h0002_0000, 0, 32'h0},
			'{OPC_PRED,   4'd1,  32'h0,         0, 32'h0},
			'{OPC_UPDATE, 4'd0,  32'h0,         0, 32'h0},
			'{OPC_READ,   4'd7,  32'h0,         0, 32'h0},
			'{OPC_WRITE,  4'd3,  32'hfff6_0000, 0, 32'h0}, // cancels R3: zero denominator
			'{OPC_UPDATE, 4'd15, 32'hffff_ffff, 0, 32'h0},
			'{OPC_READ,   4'd3,  32'h0,         0, 32'h0}
		};
		foreach (cov_est[n])
			cov_est[n] = 0;
		noise_est = '{65536, 65536, 655360, 655360};
		gaps_on = 1;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[r])
			send_cmd(dir_rows[r].op, dir_rows[r].idx, dir_rows[r].wval,
				dir_rows[r].has_lit, dir_rows[r].lit);

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: set_noise('0, '0, '0, '0);
				1: set_noise('1, '1, '1, '1);
				2: set_noise(31'($urandom), 31'($urandom), 31'($urandom), 31'($urandom));
				3: set_noise(31'($urandom_range(20'hf_ffff)), 31'($urandom_range(20'hf_ffff)),
					31'($urandom_range(24'hff_ffff)), 31'($urandom_range(24'hff_ffff)));
				default: set_noise(RstNoise0, RstNoise1, RstNoise2, RstNoise3);
			endcase
			gaps_on = (ph != 2);
			while (n_cmds < 21 + 92 * (ph + 1)) begin
				if ($urandom_range(99) < 80)
					track_burst();
				else
					noise_cmd();
			end
		end
		wait_drained();
		repeat (30) @(posedge clk);

		$display("covered %0d commands: %0d reads, %0d gain words, %0d zero denominators",
			n_cmds, n_reads, n_gains, n_div_zero);
		$display("noise settings: reset, zero, full scale, random wide and narrow");
		if (n_errors == 0 && pending_results.size() == 0)
			$display("kalman_cv_covariance_update_test: done, clean");
		else
			$display("kalman_cv_covariance_update_test: done, errors");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("timeout with %0d result words outstanding", pending_results.size());
		$display("kalman_cv_covariance_update_test: done, errors");
		$finish;
	end

endmodule

### kalman_cv_covariance_update.f
+incdir+rtl
rtl/kcv_pkg.sv
rtl/kcv_div.sv
rtl/kcv_dp.sv
rtl/kcv_ctrl.sv
rtl/kalman_cv_covariance_update.sv
rtl/kcv_chk.sv
tb/kalman_cv_covariance_update_test.sv
